// ----- hdl/aralloc_pkg.sv -----
// aralloc_pkg: shared types, codes and helpers of the address range allocator
// no dependencies; imported by the configuration, sequencer and top modules
`timescale 1ns / 1ps
`default_nettype none

package aralloc_pkg;

    // exact bound arithmetic: 32-bit addresses plus carry and sign room
    typedef logic signed [34:0] t_wide;

    // managed window as held by the configuration registers
    typedef struct packed {
        logic [31:0] low;
        logic [31:0] high;
    } t_window;

    // request kinds
    localparam logic [2:0] OP_SEARCH_UP   = 3'd0;
    localparam logic [2:0] OP_SEARCH_DOWN = 3'd1;
    localparam logic [2:0] OP_EXACT       = 3'd2;
    localparam logic [2:0] OP_FREE        = 3'd3;
    localparam logic [2:0] OP_LOOKUP      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_MISS    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    // register addresses (word index)
    localparam logic REG_WINDOW_LOW  = 1'b0;
    localparam logic REG_WINDOW_HIGH = 1'b1;

    // stream payload widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // stored region entry: attr, end, start
    localparam int ENTRY_W = 67;

    // zero-extend an address into the exact arithmetic type
    function automatic t_wide to_wide(input logic [31:0] v);
        return $signed({3'b000, v});
    endfunction

endpackage

`default_nettype wire

// ----- hdl/address_range_allocator_core.sv -----
// address_range_allocator_core: top level of the first-fit address range allocator
// free and undefined requests go straight to the result; lookup, exact and searches
// walk the region table through the one read port of the entry RAM, reading an entry and
// testing it before the next read; one request at a time
// reset: slot valid bits cleared at once, window set to the full 32-bit space, no clearing pass
// depends on aralloc_pkg, aralloc_cfg, aralloc_seq and aralloc_ram
`timescale 1ns / 1ps
`default_nettype none

module address_range_allocator_core
    import aralloc_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_SHIFT  = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // register bus
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // requests
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // address[31:0], length[63:32], attr[66:64], slot[70:67], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[2:0]
    input  wire logic [2:0]            s_axis_tuser,
    // results
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_slot[3:0], region_start[35:4], region_end[67:36], out_attr[70:68], zero pad
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic      [1:0]            m_axis_tuser
);

    localparam int KW = $clog2(MAX_REGIONS);

    t_window              window;
    logic                 ram_we;
    logic [KW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [KW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    // window registers
    aralloc_cfg #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_window (window)
    );

    // request sequencer
    aralloc_seq #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .KW          (KW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window      (window),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata)
    );

    // region entry table
    aralloc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REGIONS)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- hdl/aralloc_ram.sv -----
// aralloc_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module aralloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/aralloc_cfg.sv -----
// aralloc_cfg: window registers behind the register bus port
// depends on aralloc_pkg
`timescale 1ns / 1ps
`default_nettype none

module aralloc_cfg
    import aralloc_pkg::*;
#(
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_window          o_window
);

    localparam logic [31:0] PG_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

    logic [31:0] r_win_lo;
    logic [31:0] r_win_hi;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes, low rounded down and high rounded up to a page
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lo <= '0;
            r_win_hi <= '1;
        end else if (wr_en) begin
            if (paddr[2] == REG_WINDOW_HIGH) begin
                r_win_hi <= pwdata | PG_MASK;
            end else begin
                r_win_lo <= pwdata & ~PG_MASK;
            end
        end
    end

    // read back
    assign prdata = (paddr[2] == REG_WINDOW_HIGH) ? r_win_hi : r_win_lo;

    assign o_window.low  = r_win_lo;
    assign o_window.high = r_win_hi;

endmodule

`default_nettype wire

// ----- hdl/aralloc_seq.sv -----
// aralloc_seq: request sequencer, one shared compare unit walking the region table
// depends on aralloc_pkg; the entry table lives in an external aralloc_ram
`timescale 1ns / 1ps
`default_nettype none

module aralloc_seq
    import aralloc_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_SHIFT  = 12,
    parameter int KW          = $clog2(MAX_REGIONS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_window               i_window,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [2:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    output logic      [1:0]            m_axis_tuser,
    output logic                       o_ram_we,
    output logic      [KW-1:0]         o_ram_waddr,
    output logic      [ENTRY_W-1:0]    o_ram_wdata,
    output logic      [KW-1:0]         o_ram_raddr,
    input  wire logic [ENTRY_W-1:0]    i_ram_rdata
);

    localparam logic [31:0] PG_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [KW:0] N_CNT   = (KW+1)'(MAX_REGIONS);
    localparam logic [KW-1:0] LAST  = KW'(MAX_REGIONS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_SIZE  = 4'd2;
    localparam logic [3:0] S_SETUP = 4'd3;
    localparam logic [3:0] S_NEXT  = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CDAT  = 4'd6;
    localparam logic [3:0] S_CEVAL = 4'd7;
    localparam logic [3:0] S_KRD   = 4'd8;
    localparam logic [3:0] S_KEV   = 4'd9;
    localparam logic [3:0] S_WR    = 4'd10;
    localparam logic [3:0] S_LRD   = 4'd11;
    localparam logic [3:0] S_LEV   = 4'd12;
    localparam logic [3:0] S_RESP  = 4'd13;

    // control state
    logic [3:0]             r_state, n_state;
    logic [MAX_REGIONS-1:0] r_used, n_used;
    logic [KW:0]            r_k, n_k;
    logic                   r_first, n_first;
    logic [KW-1:0]          r_j, n_j;
    logic                   r_ok, n_ok;
    logic                   r_mv, n_mv;

    // payload state
    logic [2:0]             r_op, n_op;
    logic [31:0]            r_addr, n_addr;
    logic [31:0]            r_len, n_len;
    logic [2:0]             r_attr, n_attr;
    logic [KW-1:0]          r_fs, n_fs;
    t_wide                  r_size, n_size;
    t_wide                  r_lim, n_lim;
    t_wide                  r_a, n_a;
    t_wide                  r_b, n_b;
    t_wide                  r_best, n_best;
    logic [1:0]             r_st, n_st;
    logic [3:0]             r_rslot, n_rslot;
    logic [31:0]            r_rstart, n_rstart;
    logic [31:0]            r_rend, n_rend;
    logic [2:0]             r_rattr, n_rattr;
    logic [OUT_DATA_W-1:0]  r_mdata, n_mdata;
    logic [1:0]             r_muser, n_muser;

    // entry read data and shared arithmetic
    t_wide       ent_start;
    t_wide       ent_end;
    logic [2:0]  ent_attr;
    t_wide       lo_w;
    t_wide       hi_w;
    t_wide       addr_w;
    t_wide       mask_w;
    t_wide       end_w;
    logic [KW:0] nk;
    logic [KW-1:0] k_idx;
    logic        in_xfer;
    logic        reject;
    logic        hit;
    logic [3:0]  in_slot;

    assign ent_start = to_wide(i_ram_rdata[31:0]);
    assign ent_end   = to_wide(i_ram_rdata[63:32]);
    assign ent_attr  = i_ram_rdata[66:64];
    assign lo_w      = to_wide(i_window.low);
    assign hi_w      = to_wide(i_window.high);
    assign addr_w    = to_wide(r_addr);
    assign mask_w    = to_wide(PG_MASK);
    assign end_w     = r_a + r_size - 35'sd1;
    assign nk        = r_first ? '0 : r_k + (KW+1)'(1);
    assign k_idx     = r_k[KW-1:0];
    assign in_slot   = s_axis_tdata[70:67];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // table port
    assign o_ram_raddr = (r_state == S_KRD) ? r_j : k_idx;
    assign o_ram_we    = (r_state == S_WR);
    assign o_ram_waddr = r_fs;
    assign o_ram_wdata = {r_attr, end_w[31:0], r_a[31:0]};

    // candidate filter and overlap test
    always_comb begin
        if (r_op == OP_SEARCH_UP) begin
            reject = (r_a < r_lim) || (r_b > hi_w) || (r_ok && (r_a >= r_best));
        end else begin
            reject = (r_b > r_lim) || (r_a < lo_w) || (r_ok && (r_a <= r_best));
        end
    end

    assign hit = r_used[r_j] && (ent_start <= r_b) && (r_a <= ent_end);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_k      = r_k;
        n_first  = r_first;
        n_j      = r_j;
        n_ok     = r_ok;
        n_mv     = r_mv;
        n_op     = r_op;
        n_addr   = r_addr;
        n_len    = r_len;
        n_attr   = r_attr;
        n_fs     = r_fs;
        n_size   = r_size;
        n_lim    = r_lim;
        n_a      = r_a;
        n_b      = r_b;
        n_best   = r_best;
        n_st     = r_st;
        n_rslot  = r_rslot;
        n_rstart = r_rstart;
        n_rend   = r_rend;
        n_rattr  = r_rattr;
        n_mdata  = r_mdata;
        n_muser  = r_muser;

        // output register drains independently
        if (r_mv && m_axis_tready) begin
            n_mv = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op     = s_axis_tuser;
                    n_addr   = s_axis_tdata[31:0];
                    n_len    = s_axis_tdata[63:32];
                    n_attr   = s_axis_tdata[66:64];
                    n_st     = ST_NOSPACE;
                    n_rslot  = '0;
                    n_rstart = '0;
                    n_rend   = '0;
                    n_rattr  = '0;
                    n_k      = '0;
                    unique case (s_axis_tuser)
                        OP_SEARCH_UP, OP_SEARCH_DOWN, OP_EXACT: begin
                            n_state = S_FIND;
                        end
                        OP_LOOKUP: begin
                            n_state = S_LRD;
                        end
                        OP_FREE: begin
                            n_rslot = in_slot;
                            if ((32'(in_slot) < MAX_REGIONS) && r_used[KW'(in_slot)]) begin
                                n_used[KW'(in_slot)] = 1'b0;
                                n_st = ST_OK;
                            end else begin
                                n_st = ST_BAD;
                            end
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // lowest free slot, one per cycle
            S_FIND: begin
                if (!r_used[k_idx]) begin
                    n_fs    = k_idx;
                    n_state = S_SIZE;
                end else if (k_idx == LAST) begin
                    n_st    = ST_BAD;
                    n_state = S_RESP;
                end else begin
                    n_k = r_k + (KW+1)'(1);
                end
            end

            // round length up to pages
            S_SIZE: begin
                n_size = (to_wide(r_len) + mask_w) & ~mask_w;
                if (((to_wide(r_len) + mask_w) & ~mask_w) == '0) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SETUP;
                end
            end

            // hint checks and first candidate
            S_SETUP: begin
                n_ok    = 1'b0;
                n_first = 1'b1;
                n_j     = '0;
                unique case (r_op)
                    OP_SEARCH_UP: begin
                        if (addr_w + r_size > hi_w) begin
                            n_state = S_RESP;
                        end else begin
                            n_lim   = ((addr_w < lo_w) ? lo_w : addr_w) & ~mask_w;
                            n_a     = ((addr_w < lo_w) ? lo_w : addr_w) & ~mask_w;
                            n_b     = (((addr_w < lo_w) ? lo_w : addr_w) & ~mask_w)
                                      + r_size - 35'sd1;
                            n_state = S_CEVAL;
                        end
                    end
                    OP_SEARCH_DOWN: begin
                        if (addr_w - r_size < lo_w) begin
                            n_state = S_RESP;
                        end else begin
                            n_lim   = ((addr_w > hi_w) ? hi_w : addr_w) | mask_w;
                            n_b     = ((addr_w > hi_w) ? hi_w : addr_w) | mask_w;
                            n_a     = (((addr_w > hi_w) ? hi_w : addr_w) | mask_w)
                                      - r_size + 35'sd1;
                            n_state = S_CEVAL;
                        end
                    end
                    default: begin
                        n_a = addr_w;
                        n_b = addr_w + r_size - 35'sd1;
                        if ((addr_w < lo_w) || (addr_w + r_size - 35'sd1 > hi_w)) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_KRD;
                        end
                    end
                endcase
            end

            // step to the next stored region as a candidate
            S_NEXT: begin
                n_first = 1'b0;
                n_k     = nk;
                if (nk == N_CNT) begin
                    if (r_ok) begin
                        n_a     = r_best;
                        n_state = S_WR;
                    end else begin
                        n_state = S_RESP;
                    end
                end else if (r_used[nk[KW-1:0]]) begin
                    n_state = S_CRD;
                end
            end

            S_CRD: begin
                n_state = S_CDAT;
            end

            // candidate just above or just below a stored region
            S_CDAT: begin
                if (r_op == OP_SEARCH_UP) begin
                    n_a = ent_end + 35'sd1;
                    n_b = ent_end + r_size;
                end else begin
                    n_a = ent_start - r_size;
                    n_b = ent_start - 35'sd1;
                end
                n_state = S_CEVAL;
            end

            S_CEVAL: begin
                n_j = '0;
                if (reject) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_KRD;
                end
            end

            S_KRD: begin
                n_state = S_KEV;
            end

            // overlap test of the span against one entry
            S_KEV: begin
                if (hit) begin
                    n_state = (r_op == OP_EXACT) ? S_RESP : S_NEXT;
                end else if (r_j == LAST) begin
                    if (r_op == OP_EXACT) begin
                        n_state = S_WR;
                    end else begin
                        n_best  = r_a;
                        n_ok    = 1'b1;
                        n_state = S_NEXT;
                    end
                end else begin
                    n_j     = r_j + KW'(1);
                    n_state = S_KRD;
                end
            end

            // store the new region
            S_WR: begin
                n_used[r_fs] = 1'b1;
                n_st     = ST_OK;
                n_rslot  = 4'(r_fs);
                n_rstart = r_a[31:0];
                n_rend   = end_w[31:0];
                n_state  = S_RESP;
            end

            S_LRD: begin
                n_state = S_LEV;
            end

            // lookup of the region holding the address
            S_LEV: begin
                if (r_used[k_idx] && (addr_w >= ent_start) && (addr_w <= ent_end)) begin
                    n_st     = ST_OK;
                    n_rslot  = 4'(k_idx);
                    n_rstart = i_ram_rdata[31:0];
                    n_rend   = i_ram_rdata[63:32];
                    n_rattr  = ent_attr;
                    n_state  = S_RESP;
                end else if (k_idx == LAST) begin
                    n_st    = ST_MISS;
                    n_state = S_RESP;
                end else begin
                    n_k     = r_k + (KW+1)'(1);
                    n_state = S_LRD;
                end
            end

            // hand the result to the output register
            S_RESP: begin
                if (!r_mv || m_axis_tready) begin
                    n_mv    = 1'b1;
                    n_mdata = {1'b0, r_rattr, r_rend, r_rstart, r_rslot};
                    n_muser = r_st;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_k     <= '0;
            r_first <= 1'b0;
            r_j     <= '0;
            r_ok    <= 1'b0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_k     <= n_k;
            r_first <= n_first;
            r_j     <= n_j;
            r_ok    <= n_ok;
            r_mv    <= n_mv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_len    <= n_len;
        r_attr   <= n_attr;
        r_fs     <= n_fs;
        r_size   <= n_size;
        r_lim    <= n_lim;
        r_a      <= n_a;
        r_b      <= n_b;
        r_best   <= n_best;
        r_st     <= n_st;
        r_rslot  <= n_rslot;
        r_rstart <= n_rstart;
        r_rend   <= n_rend;
        r_rattr  <= n_rattr;
        r_mdata  <= n_mdata;
        r_muser  <= n_muser;
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

endmodule

`default_nettype wire
